@@ rtl/mfe_pkg.sv @@
// mfe_pkg: shared constants, types and the sequencer state enum for the
// multipole field evaluator. No dependencies.
`default_nettype none
package mfe_pkg;
  localparam int MaxOrder  = 8;
  localparam int FracBits  = 30;
  localparam int OrdW      = $clog2(MaxOrder);
  localparam int CntW      = 4;

  localparam logic [0:0] ActLoad = 1'b0;
  localparam logic [0:0] ActEval = 1'b1;
  localparam logic [0:0] KindNormal = 1'b0;
  localparam logic [0:0] KindSkew   = 1'b1;
  localparam logic [0:0] CfgNormalCount = 1'b0;
  localparam logic [0:0] CfgSkewCount   = 1'b1;

  localparam logic [63:0] PwrLim  = 64'd1 << 61;
  localparam logic [63:0] TermLim = 64'd1 << 58;

  typedef enum logic [1:0] {
    OP_NONE, OP_PWR, OP_TERM
  } mac_dst_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_N_RE, ST_N_IM, ST_S_RE, ST_S_IM,
    ST_P_RX, ST_P_IY, ST_P_RY, ST_P_IX, ST_P_UPD, ST_DRAIN, ST_DONE, ST_OUT
  } mfe_state_t;

  // request to the shared multiplier: go strobe, operands and saturation limit select
  typedef struct packed {
    logic              go;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic              term;   // 1: term limit, 0: power limit
  } mac_req_t;

  typedef struct packed {
    logic              valid;
    logic signed [63:0] q;
    logic              clip;
  } mac_rsp_t;
endpackage
`default_nettype wire

@@ rtl/mfe_if.sv @@
// mfe_stream_if: valid/ready channel carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface mfe_stream_if #(parameter int W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/multipole_field_evaluator.sv @@
// multipole_field_evaluator: top level, coefficient tables, sequencer and
// accumulators. Depends on mfe_pkg, mfe_stream_if, mfe_mul.
//
// channel | dir | payload
// in      | in  | action, x_position, y_position, coef_kind, coef_order, coef_value
// out     | out | field_x, field_y, saturated
// cfg     | in  | cfg_we, cfg_index, cfg_wdata (order counts)
//
// Each multiply holds the shared unit while it is issued, worked in the
// multiplier and its product taken. Per order up to four terms, then four
// power products and the update state before the next order.
// Reset is synchronous, clears the tables and sets both counts to one.
// Not ready while evaluating or while a result waits in the output register.
`default_nettype none
module multipole_field_evaluator import mfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mfe_stream_if.sink   in_ch,
  mfe_stream_if.source out_ch,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [CntW-1:0] cfg_wdata
);
  logic [CntW-1:0] nc_r, sc_r;
  logic signed [31:0] ncoef_r [MaxOrder];
  logic signed [31:0] scoef_r [MaxOrder];
  mfe_state_t st_r, st_nxt;
  logic signed [31:0] x_r, y_r;
  logic signed [63:0] re_r, im_r, rx_r, iy_r, ry_r, ix_r;
  logic signed [63:0] bx_r, by_r;
  logic [CntW-1:0] k_r, ncl, scl, top;
  logic pwr_bad_r, flag_r, wait_r;
  mac_req_t req;
  mac_rsp_t rsp;

  wire        act   = in_ch.data[100];
  wire [31:0] xin   = in_ch.data[99:68];
  wire [31:0] yin   = in_ch.data[67:36];
  wire        kind  = in_ch.data[35];
  wire [2:0]  ordin = in_ch.data[34:32];
  wire [31:0] cval  = in_ch.data[31:0];

  mfe_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign ncl = (nc_r > CntW'(MaxOrder)) ? CntW'(MaxOrder) : nc_r;
  assign scl = (sc_r > CntW'(MaxOrder)) ? CntW'(MaxOrder) : sc_r;
  assign top = (ncl > scl) ? ncl : scl;
  assign in_ch.ready = (st_r == ST_IDLE);

  // clamps
  function automatic logic signed [63:0] clamp_pwr(input logic signed [64:0] v);
    if (v > 65'sd2305843009213693952) return 64'sd2305843009213693952;
    if (v < -65'sd2305843009213693952) return -64'sd2305843009213693952;
    return v[63:0];
  endfunction
  function automatic logic pwr_over(input logic signed [64:0] v);
    return (v > 65'sd2305843009213693952) || (v < -65'sd2305843009213693952);
  endfunction
  logic signed [64:0] re_new, im_new;
  assign re_new = 65'(rx_r) - 65'(iy_r);
  assign im_new = 65'(ry_r) + 65'(ix_r);

  wire [OrdW-1:0] ki = k_r[OrdW-1:0];
  wire signed [31:0] cn = ncoef_r[ki];
  wire signed [31:0] cs = scoef_r[ki];
  wire in_s = k_r < scl;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid && act == ActEval) st_nxt = (top == '0) ? ST_DONE :
                 (ncl != '0 ? ST_N_RE : ST_S_RE);
      ST_N_RE: if (rsp.valid) st_nxt = ST_N_IM;
      ST_N_IM: if (rsp.valid) st_nxt = in_s ? ST_S_RE :
                 (k_r + 1'b1 < top ? ST_P_RX : ST_DONE);
      ST_S_RE: if (rsp.valid) st_nxt = ST_S_IM;
      ST_S_IM: if (rsp.valid) st_nxt = (k_r + 1'b1 < top) ? ST_P_RX : ST_DONE;
      ST_P_RX: if (rsp.valid) st_nxt = ST_P_IY;
      ST_P_IY: if (rsp.valid) st_nxt = ST_P_RY;
      ST_P_RY: if (rsp.valid) st_nxt = ST_P_IX;
      ST_P_IX: if (rsp.valid) st_nxt = ST_P_UPD;
      ST_P_UPD: st_nxt = (k_r + 1'b1 < ncl) ? ST_N_RE : ST_S_RE;
      ST_DONE: st_nxt = ST_OUT;
      ST_OUT: if (out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // multiplier request
  always_comb begin
    req.go = 1'b0; req.term = 1'b1; req.a = '0; req.b = '0;
    case (st_r)
      ST_N_RE: begin req.a = 64'(cn); req.b = re_r; end
      ST_N_IM: begin req.a = 64'(cn); req.b = im_r; end
      ST_S_RE: begin req.a = 64'(cs); req.b = re_r; end
      ST_S_IM: begin req.a = 64'(cs); req.b = im_r; end
      ST_P_RX: begin req.a = re_r; req.b = 64'(x_r); req.term = 1'b0; end
      ST_P_IY: begin req.a = im_r; req.b = 64'(y_r); req.term = 1'b0; end
      ST_P_RY: begin req.a = re_r; req.b = 64'(y_r); req.term = 1'b0; end
      ST_P_IX: begin req.a = im_r; req.b = 64'(x_r); req.term = 1'b0; end
      default: ;
    endcase
    req.go = !wait_r && (st_r != ST_IDLE) && (st_r != ST_P_UPD) &&
             (st_r != ST_DONE) && (st_r != ST_OUT) && (st_r != ST_DRAIN);
  end

  logic signed [64:0] sx, sy;
  always_comb begin
    sx = 65'(bx_r);
    sy = 65'(by_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; nc_r <= CntW'(1); sc_r <= CntW'(1); wait_r <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < MaxOrder; i++) begin
        ncoef_r[i] <= '0; scoef_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == CfgNormalCount) nc_r <= cfg_wdata;
        else sc_r <= cfg_wdata;
      end
      if (rsp.valid) wait_r <= 1'b0;
      else if (req.go) wait_r <= 1'b1;
      case (st_r)
        ST_IDLE: if (in_ch.valid) begin
          if (act == ActLoad) begin
            if (kind == KindSkew) scoef_r[ordin] <= cval;
            else ncoef_r[ordin] <= cval;
          end else begin
            x_r <= xin; y_r <= yin; k_r <= '0;
            re_r <= 64'sd1 << FracBits; im_r <= '0;
            bx_r <= '0; by_r <= '0; pwr_bad_r <= 1'b0; flag_r <= 1'b0;
          end
        end
        ST_N_RE: if (rsp.valid) begin
          by_r <= by_r + rsp.q;
          if (rsp.clip || (pwr_bad_r && cn != 0)) flag_r <= 1'b1;
        end
        ST_N_IM: if (rsp.valid) begin
          bx_r <= bx_r + rsp.q; if (rsp.clip) flag_r <= 1'b1;
        end
        ST_S_RE: if (rsp.valid) begin
          bx_r <= bx_r - rsp.q;
          if (rsp.clip || (pwr_bad_r && cs != 0)) flag_r <= 1'b1;
        end
        ST_S_IM: if (rsp.valid) begin
          by_r <= by_r + rsp.q; if (rsp.clip) flag_r <= 1'b1;
        end
        ST_P_RX: if (rsp.valid) begin rx_r <= rsp.q; if (rsp.clip) pwr_bad_r <= 1'b1; end
        ST_P_IY: if (rsp.valid) begin iy_r <= rsp.q; if (rsp.clip) pwr_bad_r <= 1'b1; end
        ST_P_RY: if (rsp.valid) begin ry_r <= rsp.q; if (rsp.clip) pwr_bad_r <= 1'b1; end
        ST_P_IX: if (rsp.valid) begin ix_r <= rsp.q; if (rsp.clip) pwr_bad_r <= 1'b1; end
        ST_P_UPD: begin
          re_r <= clamp_pwr(re_new); im_r <= clamp_pwr(im_new);
          if (pwr_over(re_new) || pwr_over(im_new)) pwr_bad_r <= 1'b1;
          k_r <= k_r + 1'b1;
        end
        ST_DONE: begin
          // output saturation to 48 bits
          out_ch.valid <= 1'b1;
          out_ch.data[96:49] <= (sx > 65'sd140737488355327) ? 48'h7FFF_FFFF_FFFF :
                                (sx < -65'sd140737488355328) ? 48'h8000_0000_0000 : bx_r[47:0];
          out_ch.data[48:1]  <= (sy > 65'sd140737488355327) ? 48'h7FFF_FFFF_FFFF :
                                (sy < -65'sd140737488355328) ? 48'h8000_0000_0000 : by_r[47:0];
          out_ch.data[0] <= flag_r || (bx_r[63:47] != {17{bx_r[47]}}) ||
                            (by_r[63:47] != {17{by_r[47]}});
        end
        ST_OUT: if (out_ch.ready) out_ch.valid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/mfe_mul.sv @@
// mfe_mul: shared multiply unit, floor(a*b/2^30) saturated, four 32x32
// partial products, result registered in rsp. Depends on mfe_pkg.
`default_nettype none
module mfe_mul import mfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mac_req_t req,
  output mac_rsp_t  rsp
);
  logic        neg_r, term_r, busy_r;
  logic [63:0] ua_r, ub_r;
  logic [2:0]  ph_r;
  logic [127:0] acc_r;
  logic [63:0] pp_r;
  logic [31:0] ma, mb;

  // select partial product operands by phase
  always_comb begin
    case (ph_r[1:0])
      2'd0: begin ma = ua_r[31:0];  mb = ub_r[31:0];  end
      2'd1: begin ma = ua_r[31:0];  mb = ub_r[63:32]; end
      2'd2: begin ma = ua_r[63:32]; mb = ub_r[31:0];  end
      default: begin ma = ua_r[63:32]; mb = ub_r[63:32]; end
    endcase
  end

  logic [127:0] sh;
  logic [127:0] q;
  logic         rem;
  logic [63:0]  lim;
  logic         over;
  logic [63:0]  mag;
  always_comb begin
    // pp_r holds the product formed one phase earlier
    case (ph_r)
      3'd1: sh = 128'(pp_r);
      3'd2, 3'd3: sh = 128'(pp_r) << 32;
      default: sh = 128'(pp_r) << 64;
    endcase
    q    = acc_r >> FracBits;
    rem  = |acc_r[FracBits-1:0];
    q    = q + 128'(neg_r && rem);
    lim  = term_r ? TermLim : PwrLim;
    over = (|q[127:64]) || (q[63:0] > lim);
    mag  = over ? lim : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= '0;
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= busy_r && (ph_r == 3'd5);
      if (req.go) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
        neg_r  <= req.a[63] ^ req.b[63];
        term_r <= req.term;
        ua_r   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        ub_r   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        acc_r  <= '0;
      end else if (busy_r) begin
        // products in phases 0..3, each accumulated one phase later
        if (ph_r < 3'd4) pp_r <= 64'(ma) * 64'(mb);
        if (ph_r != 3'd0 && ph_r != 3'd5) acc_r <= acc_r + sh;
        if (ph_r == 3'd5) begin
          busy_r <= 1'b0;
          rsp.clip  <= over;
          rsp.q     <= neg_r ? -$signed(mag) : $signed(mag);
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire
